// File: hw/rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared widths, constants and the arctangent table for the quaternion to
// Euler angle pipeline.
// ----------------------------------------------------------------------------
package q2e_pkg;

    localparam int CordicStepsDefault    = 16;
    localparam int ComponentWidthDefault = 16;

    localparam int WorkFrac  = 28;
    localparam int AngleFrac = 30;
    localparam int OutFrac   = 13;
    localparam int TableLen  = 24;

    // working values: up to about +-16 in Q28, plus CORDIC growth
    localparam int WorkW  = 36;
    localparam int CordW  = 40;
    localparam int AngleW = 34;

    localparam logic signed [AngleW-1:0] HalfPiQ30 = 34'sd1686629713;
    localparam logic signed [15:0] PiQ13     = 16'sd25736;
    localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;

    // arctangent of 2^-i in Q30
    function automatic logic signed [AngleW-1:0] atan_entry(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0:  v = 32'h3243F6A8;
                1:  v = 32'h1DAC6705;
                2:  v = 32'h0FADBAFC;
                3:  v = 32'h07F56EA6;
                4:  v = 32'h03FEAB76;
                5:  v = 32'h01FFD55B;
                6:  v = 32'h00FFFAAA;
                7:  v = 32'h007FFF55;
                8:  v = 32'h003FFFEA;
                9:  v = 32'h001FFFFD;
                10: v = 32'h000FFFFF;
                11: v = 32'h0007FFFF;
                12: v = 32'h0003FFFF;
                13: v = 32'h0001FFFF;
                14: v = 32'h0000FFFF;
                15: v = 32'h00007FFF;
                16: v = 32'h00003FFF;
                17: v = 32'h00001FFF;
                18: v = 32'h00000FFF;
                19: v = 32'h000007FF;
                20: v = 32'h000003FF;
                21: v = 32'h000001FF;
                22: v = 32'h000000FF;
                23: v = 32'h0000007F;
                default: v = 32'h0;
            endcase
            atan_entry = $signed({2'b00, v});
        end
    endfunction

endpackage

// File: hw/rtl/q2e_if.sv
// ----------------------------------------------------------------------------
// q2e_in_if / q2e_out_if
// Valid/ready channels for quaternion items and Euler angle results.
// ----------------------------------------------------------------------------
interface q2e_in_if #(parameter int COMPONENT_WIDTH = 16);
    logic                              valid;
    logic                              ready;
    logic signed [COMPONENT_WIDTH-1:0] quat_w;
    logic signed [COMPONENT_WIDTH-1:0] quat_x;
    logic signed [COMPONENT_WIDTH-1:0] quat_y;
    logic signed [COMPONENT_WIDTH-1:0] quat_z;
    modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
    modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface q2e_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_angle;
    logic signed [14:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
    modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    input ready);
    modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                    output ready);
endinterface

// File: hw/rtl/q2e_cordic_stage.sv
// ----------------------------------------------------------------------------
// q2e_cordic_stage
// One registered vectoring micro-rotation with a fixed shift.
// ----------------------------------------------------------------------------
module q2e_cordic_stage
    import q2e_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [CordW-1:0]  x_in,
    input  logic signed [CordW-1:0]  y_in,
    input  logic signed [AngleW-1:0] z_in,
    output logic signed [CordW-1:0]  x_out,
    output logic signed [AngleW-1:0] z_out,
    output logic signed [CordW-1:0]  y_out
);

    logic signed [CordW-1:0]  x_reg, y_reg;
    logic signed [AngleW-1:0] z_reg;
    logic signed [CordW-1:0]  x_next, y_next;
    logic signed [AngleW-1:0] z_next;

    // rotate towards the x axis
    always_comb
    begin
        if (!y_in[CordW-1])
        begin
            x_next = x_in + (y_in >>> SHIFT);
            y_next = y_in - (x_in >>> SHIFT);
            z_next = z_in + atan_entry(SHIFT);
        end
        else
        begin
            x_next = x_in - (y_in >>> SHIFT);
            y_next = y_in + (x_in >>> SHIFT);
            z_next = z_in - atan_entry(SHIFT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// File: hw/rtl/q2e_atan2.sv
// ----------------------------------------------------------------------------
// q2e_atan2
// Pipelined CORDIC atan2: quarter-turn pre-rotation stage, then one stage per
// micro-rotation. Zero vector gives zero.
// ----------------------------------------------------------------------------
module q2e_atan2
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS = CordicStepsDefault
)
(
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [WorkW-1:0]  y_in,
    input  logic signed [WorkW-1:0]  x_in,
    output logic signed [AngleW-1:0] angle
);

    localparam int N = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

    logic signed [CordW-1:0]  xs [0:N];
    logic signed [CordW-1:0]  ys [0:N];
    logic signed [AngleW-1:0] zs [0:N];
    logic                     zero_pipe_reg [0:N];

    logic signed [CordW-1:0]  x0_reg, y0_reg, x0_next, y0_next;
    logic signed [AngleW-1:0] z0_reg, z0_next;
    logic signed [CordW-1:0]  xe, ye;

    assign xe = CordW'(x_in);
    assign ye = CordW'(y_in);

    // pre-rotation into the right half plane
    always_comb
    begin
        x0_next = xe;
        y0_next = ye;
        z0_next = '0;
        if (x_in[WorkW-1])
        begin
            if (!y_in[WorkW-1])
            begin
                x0_next = ye;
                y0_next = -xe;
                z0_next = HalfPiQ30;
            end
            else
            begin
                x0_next = -ye;
                y0_next = xe;
                z0_next = -HalfPiQ30;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x0_reg           <= x0_next;
            y0_reg           <= y0_next;
            z0_reg           <= z0_next;
            zero_pipe_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    assign xs[0] = x0_reg;
    assign ys[0] = y0_reg;
    assign zs[0] = z0_reg;

    // micro-rotation chain
    for (genvar i = 0; i < N; i++)
    begin : g_stage
        q2e_cordic_stage #(.SHIFT(i)) u_stage (
            .clk   (clk),
            .en    (en),
            .x_in  (xs[i]),
            .y_in  (ys[i]),
            .z_in  (zs[i]),
            .x_out (xs[i+1]),
            .z_out (zs[i+1]),
            .y_out (ys[i+1])
        );

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zero_pipe_reg[i+1] <= zero_pipe_reg[i];
            end
        end
    end

    assign angle = zero_pipe_reg[N] ? '0 : zs[N];

endmodule

// File: hw/rtl/q2e_isqrt.sv
// ----------------------------------------------------------------------------
// q2e_isqrt
// Pipelined restoring floor square root, one result bit per stage.
// Input below 2^56, result below 2^28.
// ----------------------------------------------------------------------------
module q2e_isqrt
    import q2e_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic [2*WorkFrac-1:0] rad,
    output logic [WorkFrac-1:0]   root
);

    localparam int B  = WorkFrac;
    localparam int RW = 2*WorkFrac + 1;

    logic [RW-1:0] rem_s  [0:B];
    logic [B-1:0]  root_s [0:B];

    assign rem_s[0]  = RW'(rad);
    assign root_s[0] = '0;

    // digit-by-digit root, most significant bit first
    for (genvar k = 0; k < B; k++)
    begin : g_bit
        localparam int P = B - 1 - k;
        logic [RW-1:0] trial;
        logic [RW-1:0] rem_next;
        logic [B-1:0]  root_next;
        logic [RW-1:0] rem_reg;
        logic [B-1:0]  root_reg;

        always_comb
        begin
            trial     = (RW'(root_s[k]) << (P + 1)) + (RW'(1) << (2*P));
            rem_next  = rem_s[k];
            root_next = root_s[k];
            if (rem_s[k] >= trial)
            begin
                rem_next     = rem_s[k] - trial;
                root_next[P] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
            end
        end

        assign rem_s[k+1]  = rem_reg;
        assign root_s[k+1] = root_reg;
    end

    assign root = root_s[B];

endmodule

// File: hw/rtl/q2e_front.sv
// ----------------------------------------------------------------------------
// q2e_front
// Products of quaternion components and the five working terms, two stages.
// ----------------------------------------------------------------------------
module q2e_front
    import q2e_pkg::*;
#(
    parameter int COMPONENT_WIDTH = ComponentWidthDefault
)
(
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [COMPONENT_WIDTH-1:0] w,
    input  logic signed [COMPONENT_WIDTH-1:0] x,
    input  logic signed [COMPONENT_WIDTH-1:0] y,
    input  logic signed [COMPONENT_WIDTH-1:0] z,
    output logic signed [WorkW-1:0]           sin_r,
    output logic signed [WorkW-1:0]           cos_r,
    output logic signed [WorkW-1:0]           sin_p,
    output logic signed [WorkW-1:0]           sin_y,
    output logic signed [WorkW-1:0]           cos_y
);

    localparam int PW = 2*COMPONENT_WIDTH;
    localparam int SH = 2*(COMPONENT_WIDTH-2) - WorkFrac;

    logic signed [PW-1:0] p_reg [0:8];
    logic signed [PW-1:0] p_next [0:8];
    logic signed [WorkW-1:0] t [0:8];
    logic signed [WorkW-1:0] sin_r_reg, cos_r_reg, sin_p_reg, sin_y_reg, cos_y_reg;
    logic signed [WorkW-1:0] one;

    // products: wx yz xx yy wy zx wz xy zz
    always_comb
    begin
        p_next[0] = PW'(w) * PW'(x);
        p_next[1] = PW'(y) * PW'(z);
        p_next[2] = PW'(x) * PW'(x);
        p_next[3] = PW'(y) * PW'(y);
        p_next[4] = PW'(w) * PW'(y);
        p_next[5] = PW'(z) * PW'(x);
        p_next[6] = PW'(w) * PW'(z);
        p_next[7] = PW'(x) * PW'(y);
        p_next[8] = PW'(z) * PW'(z);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 9; i++)
            begin
                p_reg[i] <= p_next[i];
            end
        end
    end

    // rescale to Q28 with floor
    for (genvar i = 0; i < 9; i++)
    begin : g_scale
        localparam int EW = (PW > WorkW ? PW : WorkW) + (SH < 0 ? -SH : 0);
        logic signed [EW-1:0] ext;
        assign ext = EW'(p_reg[i]);
        if (SH >= 0)
        begin : g_down
            assign t[i] = WorkW'(ext >>> SH);
        end
        else
        begin : g_up
            assign t[i] = WorkW'(ext <<< (-SH));
        end
    end

    assign one = WorkW'(64'sd1 <<< WorkFrac);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_r_reg <= (t[0] + t[1]) <<< 1;
            cos_r_reg <= one - ((t[2] + t[3]) <<< 1);
            sin_p_reg <= (t[4] - t[5]) <<< 1;
            sin_y_reg <= (t[6] + t[7]) <<< 1;
            cos_y_reg <= one - ((t[3] + t[8]) <<< 1);
        end
    end

    assign sin_r = sin_r_reg;
    assign cos_r = cos_r_reg;
    assign sin_p = sin_p_reg;
    assign sin_y = sin_y_reg;
    assign cos_y = cos_y_reg;

endmodule

// File: hw/rtl/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top
// Unit quaternion in, roll/pitch/yaw (Z-Y-X) out, fully pipelined CORDIC.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : quaternion (w, x, y, z), signed Q1.14 at the default width.
//   out_ch : roll, yaw in signed Q2.13 radians, pitch in signed Q1.13, and a pitch clamp flag.
//   A transfer happens on a clock edge with valid and ready both high.
//   One item is accepted every cycle while the output side takes results.
//   Stages in order: product registers, squaring registers for pitch, 28 stages
//   of square root, a pre-rotation stage plus one stage per CORDIC step (at
//   most TableLen) of atan2 and one output register. The square root chain sets
//   the depth; roll and yaw are delayed to line up with pitch.
//   The whole pipeline advances together; when the receiver stalls with a
//   result held at the output, every stage holds and in_ch.ready drops, so
//   nothing is lost or repeated.
//   Reset clears the valid bits only; no item is in flight afterwards.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles_top
    import q2e_pkg::*;
#(
    parameter int CORDIC_STEPS    = CordicStepsDefault,
    parameter int COMPONENT_WIDTH = ComponentWidthDefault
)
(
    input logic     clk,
    input logic     rst_n,
    q2e_in_if.sink  in_ch,
    q2e_out_if.source out_ch
);

    localparam int N       = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;
    localparam int SqDepth = 2 + WorkFrac;      // magnitude, square and subtract, root
    localparam int Depth   = 2 + SqDepth + (N + 1) + 1;

    logic en;
    logic [Depth-1:0] valid_reg;

    // pipeline advances unless the output holds an untaken result
    assign en          = !valid_reg[Depth-1] || out_ch.ready;
    assign in_ch.ready = en;
    assign out_ch.valid = valid_reg[Depth-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[Depth-2:0], in_ch.valid};
        end
    end

    // working terms
    logic signed [WorkW-1:0] sin_r, cos_r, sin_p, sin_y, cos_y;

    q2e_front #(.COMPONENT_WIDTH(COMPONENT_WIDTH)) u_front (
        .clk   (clk),
        .en    (en),
        .w     (in_ch.quat_w),
        .x     (in_ch.quat_x),
        .y     (in_ch.quat_y),
        .z     (in_ch.quat_z),
        .sin_r (sin_r),
        .cos_r (cos_r),
        .sin_p (sin_p),
        .sin_y (sin_y),
        .cos_y (cos_y)
    );

    // delay roll/yaw terms and pitch sine to match the square root
    logic signed [WorkW-1:0] dl_sr_reg [0:SqDepth-1];
    logic signed [WorkW-1:0] dl_cr_reg [0:SqDepth-1];
    logic signed [WorkW-1:0] dl_sy_reg [0:SqDepth-1];
    logic signed [WorkW-1:0] dl_cy_reg [0:SqDepth-1];
    logic signed [WorkW-1:0] dl_sp_reg [0:SqDepth-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dl_sr_reg[0] <= sin_r;
            dl_cr_reg[0] <= cos_r;
            dl_sy_reg[0] <= sin_y;
            dl_cy_reg[0] <= cos_y;
            dl_sp_reg[0] <= sin_p;
            for (int i = 1; i < SqDepth; i++)
            begin
                dl_sr_reg[i] <= dl_sr_reg[i-1];
                dl_cr_reg[i] <= dl_cr_reg[i-1];
                dl_sy_reg[i] <= dl_sy_reg[i-1];
                dl_cy_reg[i] <= dl_cy_reg[i-1];
                dl_sp_reg[i] <= dl_sp_reg[i-1];
            end
        end
    end

    // pitch: 1 - s^2 for |s| < 1 (garbage otherwise, masked by clamp)
    localparam logic signed [WorkW-1:0] OneW = WorkW'(64'sd1 <<< WorkFrac);
    logic [WorkFrac:0]       mag_next;
    logic [WorkFrac-1:0]     mag_reg;
    logic [2*WorkFrac-1:0]   rad_reg;
    logic [2*WorkFrac-1:0]   sq;

    assign mag_next = sin_p[WorkW-1] ? (WorkFrac+1)'(-sin_p) : (WorkFrac+1)'(sin_p);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next[WorkFrac-1:0];
        end
    end

    assign sq = (2*WorkFrac)'(mag_reg) * (2*WorkFrac)'(mag_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg <= (2*WorkFrac)'(0) - sq;
        end
    end

    logic [WorkFrac-1:0] root;

    q2e_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .rad  (rad_reg),
        .root (root)
    );

    // three atan2 pipelines
    logic signed [AngleW-1:0] roll_a, pitch_a, yaw_a;
    logic signed [WorkW-1:0]  sp_d, root_w;

    // zero sine: the cosine is exactly one, which the root width cannot hold
    assign sp_d   = dl_sp_reg[SqDepth-1];
    assign root_w = (sp_d == '0) ? OneW : WorkW'({1'b0, root});

    q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
        .clk (clk), .en (en),
        .y_in (dl_sr_reg[SqDepth-1]), .x_in (dl_cr_reg[SqDepth-1]),
        .angle (roll_a)
    );
    q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_yaw (
        .clk (clk), .en (en),
        .y_in (dl_sy_reg[SqDepth-1]), .x_in (dl_cy_reg[SqDepth-1]),
        .angle (yaw_a)
    );
    q2e_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
        .clk (clk), .en (en),
        .y_in (sp_d), .x_in (root_w),
        .angle (pitch_a)
    );

    // clamp flags travel alongside the pitch CORDIC
    logic clamp_pos_reg [0:N];
    logic clamp_neg_reg [0:N];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            clamp_pos_reg[0] <= (sp_d >= OneW);
            clamp_neg_reg[0] <= (sp_d <= -OneW);
            for (int i = 1; i <= N; i++)
            begin
                clamp_pos_reg[i] <= clamp_pos_reg[i-1];
                clamp_neg_reg[i] <= clamp_neg_reg[i-1];
            end
        end
    end

    // round to Q13 and clamp
    localparam int Drop = AngleFrac - OutFrac;
    localparam int RW   = AngleW - Drop + 1;

    function automatic logic signed [15:0] round_clamp(
        input logic signed [AngleW-1:0] a,
        input logic signed [15:0]       lim
    );
        logic signed [AngleW:0] s;
        logic signed [RW-1:0]   r;
        begin
            s = (AngleW+1)'(a) + (AngleW+1)'(1 <<< (Drop-1));
            r = RW'(s >>> Drop);
            if (r > RW'(lim))
                round_clamp = lim;
            else if (r < -RW'(lim))
                round_clamp = -lim;
            else
                round_clamp = 16'(r);
        end
    endfunction

    logic signed [15:0] roll_reg, yaw_reg, pitch_full;
    logic signed [14:0] pitch_reg;
    logic               clamped_reg;

    assign pitch_full = round_clamp(pitch_a, HalfPiQ13);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg <= round_clamp(roll_a, PiQ13);
            yaw_reg  <= round_clamp(yaw_a, PiQ13);
            if (clamp_pos_reg[N])
                pitch_reg <= 15'(HalfPiQ13);
            else if (clamp_neg_reg[N])
                pitch_reg <= 15'(-HalfPiQ13);
            else
                pitch_reg <= pitch_full[14:0];
            clamped_reg <= clamp_pos_reg[N] || clamp_neg_reg[N];
        end
    end

    assign out_ch.roll_angle    = roll_reg;
    assign out_ch.pitch_angle   = pitch_reg;
    assign out_ch.yaw_angle     = yaw_reg;
    assign out_ch.pitch_clamped = clamped_reg;

endmodule
